// ----- rtl/zscore_normalizer_unit_macros.svh -----
// Assertion macros used by the checker file of the z-score normalizer.
`ifndef ZSCORE_NORMALIZER_UNIT_MACROS_SVH
`define ZSCORE_NORMALIZER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ZN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zscore_normalizer_unit: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ZN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zscore_normalizer_unit: next-cycle check failed");

// Implication that is also checked across reset.
`define ZN_ASSERT_ALW(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("zscore_normalizer_unit: reset check failed");

`endif

// ----- rtl/zn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package zn_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int SUM_W      = 23;
  localparam int ACC_W      = 40;
  localparam int DIVD_W     = 41;
  localparam int DIVS_W     = 28;
  localparam int ROOT_W     = 56;
  localparam int ROOT_STEPS = 28;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam logic [31:0] FLOOR_RESET = 32'd66;
  localparam logic [2:0]  ADDR_VARIANCE_FLOOR = 3'd0;

  typedef struct packed {
    logic               last;
    logic signed [15:0] sample;
  } zn_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MEAN_START,
    ST_MEAN_WAIT,
    ST_DEV_RD,
    ST_DEV_MUL,
    ST_DEV_ACC,
    ST_CHECK,
    ST_VAR_WAIT,
    ST_SQRT,
    ST_SQRT_DONE,
    ST_RECIP_WAIT,
    ST_OUT_RD,
    ST_OUT_MUL,
    ST_OUT_EMIT
  } zn_state_t;

endpackage
`default_nettype wire

// ----- rtl/zn_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module zn_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire zn_pkg::zn_item_t push_item,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output zn_pkg::zn_item_t      pop_item
);
  import zn_pkg::*;

  zn_item_t slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic do_push;
  logic do_pop;

  assign full      = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_item  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (!do_push && do_pop) fill <= fill - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/zn_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module zn_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [zn_pkg::DIVD_W-1:0]   dividend,
  input  wire logic [zn_pkg::DIVS_W-1:0]   divisor,
  output logic                             done,
  output logic [zn_pkg::DIVD_W-1:0]        quotient
);
  import zn_pkg::*;

  // Restoring division, one quotient bit per cycle.
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [5:0]        step;
  logic              busy;
  logic [DIVS_W:0]   trial;
  logic              fits;

  assign trial = {rem, quotient[DIVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= fits ? DIVS_W'(trial - {1'b0, dvs}) : trial[DIVS_W-1:0];
      quotient <= {quotient[DIVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == 6'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/zn_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module zn_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [31:0]      variance_floor,
  input  wire logic             item_valid,
  input  wire zn_pkg::zn_item_t item,
  output logic                  item_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [15:0]           out_data,
  output logic                  out_last
);
  import zn_pkg::*;

  zn_state_t state;
  zn_state_t state_next;

  logic signed [15:0] store [MAX_ITEMS];
  logic signed [15:0] rdata;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic signed [SUM_W-1:0] sum;
  logic [ACC_W-1:0]   acc;
  logic signed [16:0] mean;
  logic [31:0]        sq;
  logic [31:0]        inv;
  logic               scale;
  logic [ROOT_W-1:0]  rv;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W-1:0]  rbit;
  logic [4:0]         rstep;
  logic signed [16:0] dreg;
  logic [48:0]        prod;

  logic               div_start;
  logic [DIVD_W-1:0]  div_dividend;
  logic [DIVS_W-1:0]  div_divisor;
  logic               div_done;
  logic [DIVD_W-1:0]  div_q;

  logic               store_ok;
  logic [21:0]        sum_mag;
  logic signed [16:0] dev;
  logic [16:0]        dev_mag;
  logic [ROOT_W-1:0]  rtrial;
  logic               last_idx;
  logic               out_free;
  logic [35:0]        mag13;
  logic signed [19:0] dev8;
  logic [15:0]        result;

  assign store_ok = (count < CNT_W'(MAX_ITEMS));
  assign sum_mag  = sum[SUM_W-1] ? 22'(-sum) : 22'(sum);
  assign dev      = 17'(rdata) - mean;
  assign dev_mag  = dev[16] ? 17'(-dev) : 17'(dev);
  assign rtrial   = root + rbit;
  assign last_idx = (idx == count - 1'b1);
  assign out_free = !out_valid || out_ready;
  assign mag13    = prod[48:13];
  assign dev8     = {dreg, 3'b000};

  zn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (scale) begin
      if (dreg[16]) begin
        result = (mag13 >= 36'd32768) ? 16'h8000 : 16'(-mag13[15:0]);
      end else begin
        result = (mag13 > 36'd32767) ? 16'h7FFF : mag13[15:0];
      end
    end else begin
      if (dev8 > 20'sd32767) result = 16'h7FFF;
      else if (dev8 < -20'sd32768) result = 16'h8000;
      else result = dev8[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    item_pop     = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIVD_W'(acc);
    div_divisor  = DIVS_W'(count);
    case (state)
      ST_LOAD: begin
        item_pop = item_valid;
        if (item_valid && item.last) state_next = ST_MEAN_START;
      end
      ST_MEAN_START: begin
        div_start    = 1'b1;
        div_dividend = DIVD_W'(sum_mag);
        state_next   = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: if (div_done) state_next = ST_DEV_RD;
      ST_DEV_RD:    state_next = ST_DEV_MUL;
      ST_DEV_MUL:   state_next = ST_DEV_ACC;
      ST_DEV_ACC:   state_next = last_idx ? ST_CHECK : ST_DEV_RD;
      ST_CHECK: begin
        if (acc >= ACC_W'(variance_floor)) begin
          div_start  = 1'b1;
          state_next = ST_VAR_WAIT;
        end else begin
          state_next = ST_OUT_RD;
        end
      end
      ST_VAR_WAIT: if (div_done) state_next = ST_SQRT;
      ST_SQRT: if (rstep == 5'(ROOT_STEPS - 1)) state_next = ST_SQRT_DONE;
      ST_SQRT_DONE: begin
        if (root != '0) begin
          div_start    = 1'b1;
          div_dividend = DIVD_W'(64'h1_0000_0000);
          div_divisor  = root[DIVS_W-1:0];
          state_next   = ST_RECIP_WAIT;
        end else begin
          state_next = ST_OUT_RD;
        end
      end
      ST_RECIP_WAIT: if (div_done) state_next = ST_OUT_RD;
      ST_OUT_RD:  state_next = ST_OUT_MUL;
      ST_OUT_MUL: state_next = ST_OUT_EMIT;
      ST_OUT_EMIT: begin
        if (out_free) state_next = last_idx ? ST_LOAD : ST_OUT_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Sample store: one write port while loading, one registered read port.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD && item_valid && store_ok) begin
      store[count[IDX_W-1:0]] <= item.sample;
    end
    rdata <= store[idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sum       <= '0;
      acc       <= '0;
      inv       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT_EMIT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_LOAD: begin
          idx <= '0;
          if (item_valid && store_ok) begin
            count <= count + 1'b1;
            sum   <= sum + SUM_W'(item.sample);
          end
        end
        ST_MEAN_WAIT: begin
          acc <= '0;
          if (div_done) mean <= sum[SUM_W-1] ? 17'(-div_q[16:0]) : div_q[16:0];
        end
        ST_DEV_MUL: sq <= 32'(dev * dev);
        ST_DEV_ACC: begin
          acc <= acc + ACC_W'(sq);
          idx <= last_idx ? '0 : idx + 1'b1;
        end
        ST_CHECK: begin
          scale <= (acc >= ACC_W'(variance_floor));
          if (acc < ACC_W'(variance_floor)) inv <= '0;
        end
        ST_VAR_WAIT: begin
          rv    <= {div_q[39:0], 16'h0000};
          root  <= '0;
          rbit  <= ROOT_W'(1) << 54;
          rstep <= '0;
        end
        ST_SQRT: begin
          if (rv >= rtrial) begin
            rv   <= rv - rtrial;
            root <= (root >> 1) + rbit;
          end else begin
            root <= root >> 1;
          end
          rbit  <= rbit >> 2;
          rstep <= rstep + 1'b1;
        end
        ST_SQRT_DONE: if (root == '0) inv <= 32'hFFFF_FFFF;
        ST_RECIP_WAIT: begin
          if (div_done) inv <= (div_q[DIVD_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
        end
        ST_OUT_MUL: begin
          dreg <= dev;
          prod <= 49'(dev_mag) * 49'(inv);
        end
        ST_OUT_EMIT: begin
          if (out_free) begin
            out_data  <= result;
            out_last  <= last_idx;
            idx       <= idx + 1'b1;
            if (last_idx) begin
              count <= '0;
              sum   <= '0;
              acc   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/zscore_normalizer_unit.sv -----
// Z-score normalizer. Samples (signed Q8.8) arrive on the s_ stream, one per transfer, and
// the transfer with s_tlast high closes a vector of up to 64 samples; samples beyond 64
// are dropped, but their tlast still closes the vector. After the closing sample the unit
// computes the mean (truncated toward zero) and the sum of squared deviations, then sends
// one Q4.11 result per stored sample on the m_ stream, in load order, with m_tlast on the
// final one. If the deviation sum is at or above the variance_floor register (APB address
// 0, Q16.16, reset 66) each centered sample is scaled by 1/sqrt(sum/count); otherwise it
// is only centered. Results saturate. After loading, the unit runs the mean division, the
// deviation pass and the floor check, then variance division, square root and reciprocal
// when scaling, and the output pass, which also waits while m_tready is held low; the pace
// is set by the single sample store read port and the bit-serial divider and root units.
// A four-entry queue ahead of the compute engine keeps accepting samples of the next vector
// while the current one is still being processed, until it fills.
`timescale 1ns / 1ps
`default_nettype none
module zscore_normalizer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] sample
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [15:0] normalized
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import zn_pkg::*;

  logic [31:0] variance_floor;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  zn_item_t    q_in;
  zn_item_t    q_out;

  // The configuration register is written in the access phase of an APB write.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_VARIANCE_FLOOR) ? variance_floor : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      variance_floor <= FLOOR_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_VARIANCE_FLOOR) begin
      variance_floor <= pwdata;
    end
  end

  // Front side: every accepted transfer is queued with its end-of-vector mark.
  assign s_tready    = !q_full;
  assign q_in.sample = s_tdata;
  assign q_in.last   = s_tlast;

  zn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_out)
  );

  // Back side: stores the vector, runs the statistics and drives the result stream.
  zn_back u_back (
    .clk            (clk),
    .rst            (rst),
    .variance_floor (variance_floor),
    .item_valid     (q_valid),
    .item           (q_out),
    .item_pop       (q_pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_data       (m_tdata),
    .out_last       (m_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/zn_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "zscore_normalizer_unit_macros.svh"
module zn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        pready
);
  // A stalled result stays offered.
  `ZN_ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
  // A stalled result keeps its payload.
  `ZN_ASSERT_NXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
  // The register port never waits.
  `ZN_ASSERT_IMP(a_pready, 1'b1, pready)
  // Nothing is offered right after reset.
  `ZN_ASSERT_ALW(a_reset_quiet, $past(rst), !m_tvalid)
endmodule

bind zscore_normalizer_unit zn_checker u_zn_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .pready   (pready)
);
`default_nettype wire
